// ===== rtl/bdd_pkg.sv =====
// Shared constants, types and codes of the block density detector.
`default_nettype none
package bdd_pkg;

  // frame geometry
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int BLOCK      = 5;

  // field and register widths
  localparam int PIXEL_W    = 8;
  localparam int SIZE_W     = 12;
  localparam int LIMIT_W    = 23;
  localparam int DENSE_W    = 18;
  localparam int TOTAL_W    = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  // register reset values
  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;
  localparam int RST_LIMIT  = 10000;

  // position counters
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_POS_W = $clog2(MAX_HEIGHT);
  localparam int MOD_W     = $clog2(BLOCK);
  localparam int PROD_W    = SIZE_W + 1;

  // block accumulators: two entries per memory row, one valid flop per row
  localparam int ACC_DEPTH = MAX_WIDTH / BLOCK + 1;
  localparam int BC_W      = $clog2(ACC_DEPTH);
  localparam int BR_W      = $clog2(MAX_HEIGHT / BLOCK + 1);
  localparam int ACC_W     = $clog2(BLOCK * BLOCK + 1);
  localparam int ACC_ROWS  = (ACC_DEPTH + 1) / 2;
  localparam int ROW_W     = BC_W - 1;
  localparam int DENSE_THR = (BLOCK * BLOCK) / 2;

  // dense > (total / B^2) / 2  <=>  total < dense * 2 * B^2
  localparam int SCALE    = 2 * BLOCK * BLOCK;
  localparam int SCALED_W = DENSE_W + $clog2(SCALE);

  // front-to-back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_LIMIT  = 2'd2
  } cfg_idx_e;

  // one classified pixel
  typedef struct packed {
    logic            set;
    logic            acc_en;
    logic            blk_end;
    logic            frame_end;
    logic [BC_W-1:0] bc;
  } op_t;

endpackage
`default_nettype wire

// ===== rtl/bdd_if.sv =====
// Stream interfaces: pixel input and frame result.
`default_nettype none
interface bdd_pix_if;
  logic                         valid;
  logic                         ready;
  logic [bdd_pkg::PIXEL_W-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bdd_res_if;
  logic                         valid;
  logic                         ready;
  logic                         detected;
  logic [bdd_pkg::DENSE_W-1:0]  dense_blocks;
  logic [bdd_pkg::TOTAL_W-1:0]  set_pixels;

  modport source (output valid, output detected, output dense_blocks, output set_pixels,
                  input ready);
  modport sink   (input valid, input detected, input dense_blocks, input set_pixels,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/bdd_front.sv =====
// Front end: accepts pixels, tracks raster position and classifies each pixel.
`default_nettype none
module bdd_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [bdd_pkg::SIZE_W-1:0]  width_i,
  input  wire logic [bdd_pkg::SIZE_W-1:0]  height_i,
  bdd_pix_if.sink                          pix_i,
  input  wire logic                        q_full_i,
  output logic                             push_o,
  output bdd_pkg::op_t                     op_o
);

  logic [bdd_pkg::COL_W-1:0]     col_q, col_d;
  logic [bdd_pkg::MOD_W-1:0]     cmod_q, cmod_d;
  logic [bdd_pkg::BC_W-1:0]      bc_q, bc_d;
  logic [bdd_pkg::ROW_POS_W-1:0] row_q, row_d;
  logic [bdd_pkg::MOD_W-1:0]     rmod_q, rmod_d;
  logic [bdd_pkg::BR_W-1:0]      br_q, br_d;

  logic fire;
  logic last_col, last_row;
  logic col_in, row_in;

  assign pix_i.ready = !q_full_i;
  assign fire        = pix_i.valid && !q_full_i;
  assign push_o      = fire;

  assign last_col = bdd_pkg::SIZE_W'(col_q) >= (width_i - bdd_pkg::SIZE_W'(1));
  assign last_row = bdd_pkg::SIZE_W'(row_q) >= (height_i - bdd_pkg::SIZE_W'(1));

  // block fully inside the frame: BLOCK * (index + 1) <= size
  assign col_in = (bdd_pkg::PROD_W'(bdd_pkg::BLOCK) *
                   (bdd_pkg::PROD_W'(bc_q) + bdd_pkg::PROD_W'(1)))
                  <= bdd_pkg::PROD_W'(width_i);
  assign row_in = (bdd_pkg::PROD_W'(bdd_pkg::BLOCK) *
                   (bdd_pkg::PROD_W'(br_q) + bdd_pkg::PROD_W'(1)))
                  <= bdd_pkg::PROD_W'(height_i);

  always_comb begin
    op_o.set       = pix_i.pixel != '0;
    op_o.acc_en    = col_in && row_in;
    op_o.blk_end   = (cmod_q == bdd_pkg::MOD_W'(bdd_pkg::BLOCK - 1)) &&
                     (rmod_q == bdd_pkg::MOD_W'(bdd_pkg::BLOCK - 1));
    op_o.frame_end = last_col && last_row;
    op_o.bc        = bc_q;
  end

  always_comb begin
    col_d  = col_q;
    cmod_d = cmod_q;
    bc_d   = bc_q;
    row_d  = row_q;
    rmod_d = rmod_q;
    br_d   = br_q;
    if (fire) begin
      if (!last_col) begin
        col_d = col_q + bdd_pkg::COL_W'(1);
        if (cmod_q == bdd_pkg::MOD_W'(bdd_pkg::BLOCK - 1)) begin
          cmod_d = '0;
          bc_d   = bc_q + bdd_pkg::BC_W'(1);
        end else begin
          cmod_d = cmod_q + bdd_pkg::MOD_W'(1);
        end
      end else begin
        col_d  = '0;
        cmod_d = '0;
        bc_d   = '0;
        if (!last_row) begin
          row_d = row_q + bdd_pkg::ROW_POS_W'(1);
          if (rmod_q == bdd_pkg::MOD_W'(bdd_pkg::BLOCK - 1)) begin
            rmod_d = '0;
            br_d   = br_q + bdd_pkg::BR_W'(1);
          end else begin
            rmod_d = rmod_q + bdd_pkg::MOD_W'(1);
          end
        end else begin
          row_d  = '0;
          rmod_d = '0;
          br_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      cmod_q <= '0;
      bc_q   <= '0;
      row_q  <= '0;
      rmod_q <= '0;
      br_q   <= '0;
    end else begin
      col_q  <= col_d;
      cmod_q <= cmod_d;
      bc_q   <= bc_d;
      row_q  <= row_d;
      rmod_q <= rmod_d;
      br_q   <= br_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bdd_queue.sv =====
// Short FIFO of classified pixels between front and back end.
`default_nettype none
module bdd_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire bdd_pkg::op_t op_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              empty_o,
  output bdd_pkg::op_t      op_o
);

  bdd_pkg::op_t                slot_q [bdd_pkg::QUEUE_DEPTH];
  logic [bdd_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [bdd_pkg::QPTR_W:0]    count_q, count_d;
  logic                        do_push, do_pop;

  assign full_o  = count_q == (bdd_pkg::QPTR_W + 1)'(bdd_pkg::QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign op_o    = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (bdd_pkg::QPTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (bdd_pkg::QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + bdd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + bdd_pkg::QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bdd_back.sv =====
// Back end: block accumulator memory, frame totals, verdict and result register.
`default_nettype none
module bdd_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [bdd_pkg::LIMIT_W-1:0]  limit_i,
  input  wire logic                         q_empty_i,
  input  wire bdd_pkg::op_t                 q_op_i,
  output logic                              q_pop_o,
  bdd_res_if.source                         res_o
);

  localparam int WORD_W = 2 * bdd_pkg::ACC_W;

  logic [WORD_W-1:0]            acc_mem [bdd_pkg::ACC_ROWS];
  logic [WORD_W-1:0]            rd_q;
  logic [bdd_pkg::ACC_ROWS-1:0] row_vld_q;

  logic                         b2_valid_q;
  bdd_pkg::op_t                 b2_q;
  logic                         fwd_q;
  logic [WORD_W-1:0]            fwd_word_q;

  logic [bdd_pkg::TOTAL_W-1:0]  set_total_q, set_total_d;
  logic [bdd_pkg::DENSE_W-1:0]  dense_total_q, dense_total_d;
  logic [bdd_pkg::SCALED_W-1:0] scaled_q, scaled_d;

  logic                         out_vld_q;
  logic                         out_det_q;
  logic [bdd_pkg::DENSE_W-1:0]  out_dense_q;
  logic [bdd_pkg::TOTAL_W-1:0]  out_total_q;

  logic                         out_free, b2_adv, b2_fire, pop, wr_en, same_row;
  logic [bdd_pkg::ROW_W-1:0]    row_idx, pop_row;
  logic [WORD_W-1:0]            word_cur, word_new;
  logic [bdd_pkg::ACC_W-1:0]    acc_cur, acc_inc, acc_new;
  logic                         dense_inc, det;

  // only a frame-end op waits, and only for a full result register
  assign out_free = !out_vld_q || res_o.ready;
  assign b2_adv   = !b2_valid_q || !b2_q.frame_end || out_free;
  assign b2_fire  = b2_valid_q && b2_adv;
  assign pop      = b2_adv && !q_empty_i;
  assign q_pop_o  = pop;

  assign row_idx  = b2_q.bc[bdd_pkg::BC_W-1:1];
  assign pop_row  = q_op_i.bc[bdd_pkg::BC_W-1:1];
  assign wr_en    = b2_fire && b2_q.acc_en;
  assign same_row = pop_row == row_idx;

  // forwarded word covers the write that raced the registered read
  always_comb begin
    if (fwd_q) begin
      word_cur = fwd_word_q;
    end else if (row_vld_q[row_idx]) begin
      word_cur = rd_q;
    end else begin
      word_cur = '0;
    end
    acc_cur = b2_q.bc[0] ? word_cur[WORD_W-1:bdd_pkg::ACC_W]
                         : word_cur[bdd_pkg::ACC_W-1:0];
    // saturate: only the majority test reads the count
    acc_inc = (b2_q.set && acc_cur != '1) ? acc_cur + bdd_pkg::ACC_W'(1) : acc_cur;
    acc_new = b2_q.blk_end ? '0 : acc_inc;
    word_new = b2_q.bc[0] ? {acc_new, word_cur[bdd_pkg::ACC_W-1:0]}
                          : {word_cur[WORD_W-1:bdd_pkg::ACC_W], acc_new};
  end

  always_comb begin
    dense_inc = b2_q.acc_en && b2_q.blk_end &&
                (acc_inc > bdd_pkg::ACC_W'(bdd_pkg::DENSE_THR)) && (dense_total_q != '1);
    set_total_d   = (b2_q.set && set_total_q != '1) ?
                    set_total_q + bdd_pkg::TOTAL_W'(1) : set_total_q;
    dense_total_d = dense_inc ? dense_total_q + bdd_pkg::DENSE_W'(1) : dense_total_q;
    scaled_d      = dense_inc ? scaled_q + bdd_pkg::SCALED_W'(bdd_pkg::SCALE) : scaled_q;
    det = (set_total_d > limit_i) || (bdd_pkg::SCALED_W'(set_total_d) < scaled_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_valid_q    <= 1'b0;
      fwd_q         <= 1'b0;
      row_vld_q     <= '0;
      set_total_q   <= '0;
      dense_total_q <= '0;
      scaled_q      <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      if (b2_adv) begin
        b2_valid_q <= !q_empty_i;
        fwd_q      <= pop && wr_en && !b2_q.frame_end && same_row;
      end
      if (b2_fire) begin
        if (b2_q.frame_end) begin
          row_vld_q     <= '0;
          set_total_q   <= '0;
          dense_total_q <= '0;
          scaled_q      <= '0;
        end else begin
          if (wr_en) begin
            row_vld_q[row_idx] <= 1'b1;
          end
          set_total_q   <= set_total_d;
          dense_total_q <= dense_total_d;
          scaled_q      <= scaled_d;
        end
      end
      if (b2_fire && b2_q.frame_end) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b2_adv) begin
      b2_q       <= q_op_i;
      fwd_word_q <= word_new;
    end
    if (b2_fire && b2_q.frame_end) begin
      out_det_q   <= det;
      out_dense_q <= dense_total_d;
      out_total_q <= set_total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      acc_mem[row_idx] <= word_new;
    end
    if (pop) begin
      rd_q <= acc_mem[pop_row];
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.detected     = out_det_q;
  assign res_o.dense_blocks = out_dense_q;
  assign res_o.set_pixels   = out_total_q;

`ifndef SYNTH
  a_stall_only_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b2_valid_q && !b2_adv |-> b2_q.frame_end && out_vld_q)
    else $error("back end stalled without a pending result");

  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b2_fire && b2_q.frame_end |=> set_total_q == '0 && dense_total_q == '0 &&
                                  row_vld_q == '0)
    else $error("frame state not cleared after last pixel");

  a_scaled_tracks_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scaled_q == bdd_pkg::SCALED_W'(dense_total_q) * bdd_pkg::SCALED_W'(bdd_pkg::SCALE))
    else $error("scaled dense count out of step");

  a_fwd_with_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> b2_valid_q)
    else $error("forwarding flag without an op in the back stage");
`endif

endmodule
`default_nettype wire

// ===== rtl/block_density_detector_core.sv =====
// Top level of the block density detector: config registers, front, queue, back.
//
//   channel   dir  handshake          payload
//   pix_i     in   valid/ready        pixel[7:0]
//   res_o     out  valid/ready        detected, dense_blocks[17:0], set_pixels[22:0]
//   cfg       in   cfg_we_i           cfg_idx_i[1:0], cfg_wdata_i[22:0]
//
// One pixel per cycle while results are taken; the front counts position, the back does one
// read-modify-write of the accumulator memory per pixel.
// A result is registered once the frame's last pixel has passed the queue and back stage.
// Accumulator rows carry valid flops cleared at reset and at frame end: no clearing pass.
// An untaken result stalls the next frame end; the queue then fills and ready drops.
`default_nettype none
module block_density_detector_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bdd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bdd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  bdd_pix_if.sink                              pix_i,
  bdd_res_if.source                            res_o
);

  logic [bdd_pkg::SIZE_W-1:0]  width_q, height_q;
  logic [bdd_pkg::LIMIT_W-1:0] limit_q;

  logic         push, q_full, q_empty, q_pop;
  bdd_pkg::op_t front_op, q_op;

  // sizes are stored already clamped to 1..max
  function automatic logic [bdd_pkg::SIZE_W-1:0] clamp_size(
    input logic [bdd_pkg::SIZE_W-1:0] v,
    input logic [bdd_pkg::SIZE_W-1:0] maxv
  );
    logic [bdd_pkg::SIZE_W-1:0] r;
    if (v == '0) begin
      r = bdd_pkg::SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bdd_pkg::SIZE_W'(bdd_pkg::RST_WIDTH);
      height_q <= bdd_pkg::SIZE_W'(bdd_pkg::RST_HEIGHT);
      limit_q  <= bdd_pkg::LIMIT_W'(bdd_pkg::RST_LIMIT);
    end else if (cfg_we_i) begin
      unique case (bdd_pkg::cfg_idx_e'(cfg_idx_i))
        bdd_pkg::CFG_WIDTH: begin
          width_q <= clamp_size(cfg_wdata_i[bdd_pkg::SIZE_W-1:0],
                                bdd_pkg::SIZE_W'(bdd_pkg::MAX_WIDTH));
        end
        bdd_pkg::CFG_HEIGHT: begin
          height_q <= clamp_size(cfg_wdata_i[bdd_pkg::SIZE_W-1:0],
                                 bdd_pkg::SIZE_W'(bdd_pkg::MAX_HEIGHT));
        end
        bdd_pkg::CFG_LIMIT: begin
          limit_q <= cfg_wdata_i[bdd_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  bdd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .width_i  (width_q),
    .height_i (height_q),
    .pix_i    (pix_i),
    .q_full_i (q_full),
    .push_o   (push),
    .op_o     (front_op)
  );

  bdd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .op_o    (q_op)
  );

  bdd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .limit_i   (limit_q),
    .q_empty_i (q_empty),
    .q_op_i    (q_op),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule
`default_nettype wire
